[design/cau_pkg.sv]
// Shared constants, operation codes and arctangent table for the complex ALU.
// No dependencies; imported by complex_arithmetic_unit, cau_cordic and the simulation files.
`default_nettype none

package cau_pkg;

  localparam int FIELD_W      = 32;
  localparam int FUNC_W       = 4;
  localparam int TOL_W        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_W       = 2 * FIELD_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int ANG_W        = 64;
  localparam int CORDIC_STEPS = 62;
  localparam int QUO_BITS     = FIELD_W;
  localparam int ROOT_BITS    = FIELD_W;
  localparam int LO_W         = QUO_BITS - FRAC_BITS;
  localparam int NORM_TOP     = 59;
  localparam int ANG_SHIFT    = 60 - FRAC_BITS;

  localparam logic [ANG_W-1:0] PI_Q60            = 64'h3243F6A8885A308D;
  localparam logic [ANG_W-1:0] HALF_PI_Q60       = 64'h1921FB54442D1846;
  localparam logic [ANG_W-1:0] THREE_HALF_PI_Q60 = 64'h4B65F1FCCC8748D3;
  localparam logic [ANG_W-1:0] TWO_PI_Q60        = 64'h6487ED5110B4611A;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_MUL     = 4'd2,
    FN_DIV     = 4'd3,
    FN_NEG     = 4'd4,
    FN_CONJ    = 4'd5,
    FN_ABS     = 4'd6,
    FN_ARG     = 4'd7,
    FN_EQUAL   = 4'd8,
    FN_IS_REAL = 4'd9
  } func_t;

  // x / (2k+1) for the series terms of the arctangent
  function automatic logic [63:0] odd_div(logic [63:0] x, int k);
    logic [63:0] t;
    case (k)
      0: t = x / 1;    1: t = x / 3;    2: t = x / 5;    3: t = x / 7;
      4: t = x / 9;    5: t = x / 11;   6: t = x / 13;   7: t = x / 15;
      8: t = x / 17;   9: t = x / 19;   10: t = x / 21;  11: t = x / 23;
      12: t = x / 25;  13: t = x / 27;  14: t = x / 29;  15: t = x / 31;
      16: t = x / 33;  17: t = x / 35;  18: t = x / 37;  19: t = x / 39;
      20: t = x / 41;  21: t = x / 43;  22: t = x / 45;  23: t = x / 47;
      24: t = x / 49;  25: t = x / 51;  26: t = x / 53;  27: t = x / 55;
      28: t = x / 57;  29: t = x / 59;  30: t = x / 61;
      default: t = '0;
    endcase
    return t;
  endfunction

  // atan(2^-i) in Q62, evaluated at elaboration for each CORDIC stage
  function automatic logic [63:0] atan_q62(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q60;
    end else begin
      for (int k = 0; k <= 30; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = odd_div(64'd1 << (62 - e), k);
          if (k[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[design/cau_cordic.sv]
// Pipelined vectoring CORDIC: one micro-rotation per register stage.
// Depends on cau_pkg for the step count and the arctangent table.
`default_nettype none

module cau_cordic (
  input  logic                              clk,
  input  logic signed [cau_pkg::ANG_W-1:0]  x_in,
  input  logic signed [cau_pkg::ANG_W-1:0]  y_in,
  output logic signed [cau_pkg::ANG_W-1:0]  z_out
);
  import cau_pkg::*;

  logic signed [ANG_W-1:0] x_q [1:CORDIC_STEPS];
  logic signed [ANG_W-1:0] y_q [1:CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_q [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_q62(i);
    logic signed [ANG_W-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = '0;
    end else begin : g_next
      assign xi = x_q[i];
      assign yi = y_q[i];
      assign zi = z_q[i];
    end
    // rotate toward the x axis, sign of y picks the direction
    always_ff @(posedge clk) begin
      if (!yi[ANG_W-1]) begin
        x_q[i+1] <= xi + (yi >>> i);
        y_q[i+1] <= yi - (xi >>> i);
        z_q[i+1] <= zi + ATAN_I;
      end else begin
        x_q[i+1] <= xi - (yi >>> i);
        y_q[i+1] <= yi + (xi >>> i);
        z_q[i+1] <= zi - ATAN_I;
      end
    end
  end

  assign z_out = z_q[CORDIC_STEPS];

endmodule

`default_nettype wire

[design/complex_arithmetic_unit.sv]
// Top level of the fixed-point complex ALU: operand stages, pipelined divider,
// square root and argument path. Depends on cau_pkg and cau_cordic.
//
// Usage:
//   Input: drive func, a_re, a_im, b_re, b_im and raise start; the word is
//   taken at each rising edge with start high and busy low. busy is high while
//   rst is held and up to the first edge after it, low at all other times, so
//   a word may enter every cycle.
//   Output: each word gives one result on res_re, res_im, flag and fault,
//   shown for exactly one cycle with done high. The receiver cannot stall.
//   Every operation takes the same path, so results leave in the order in
//   which their words were taken. Throughput: one word per cycle.
//   The depth is set by the 62-stage CORDIC of the argument path; the 32-stage
//   divider and square root are delayed to line up with it.
//   Configuration: cfg_data is written to the tolerance register when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write only
//   while no word is in flight.
//   Reset (rst, synchronous): drops every word in flight, sets tolerance to 1.
`default_nettype none

module complex_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [cau_pkg::FUNC_W-1:0]          func,
  input  logic signed [cau_pkg::FIELD_W-1:0]  a_re,
  input  logic signed [cau_pkg::FIELD_W-1:0]  a_im,
  input  logic signed [cau_pkg::FIELD_W-1:0]  b_re,
  input  logic signed [cau_pkg::FIELD_W-1:0]  b_im,
  output logic                                done,
  output logic signed [cau_pkg::FIELD_W-1:0]  res_re,
  output logic signed [cau_pkg::FIELD_W-1:0]  res_im,
  output logic                                flag,
  output logic                                fault,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cau_pkg::TOL_W-1:0]           cfg_data
);
  import cau_pkg::*;

  localparam int LAST = 3 + CORDIC_STEPS + 1;
  localparam int DLY  = CORDIC_STEPS - QUO_BITS;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((66'sd1 <<< (DATA_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 1;
  localparam logic [QUO_BITS-1:0] POS_LIM = QUO_BITS'((64'd1 << (DATA_WIDTH - 1)) - 1);
  localparam logic [QUO_BITS-1:0] NEG_LIM = QUO_BITS'(64'd1 << (DATA_WIDTH - 1));

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [FIELD_W-1:0] res_re;
    logic signed [FIELD_W-1:0] res_im;
    logic                      flag;
    logic                      nz;
    logic                      dneg_re;
    logic                      dneg_im;
    logic                      re_neg;
    logic                      re_zero;
    logic                      im_neg;
    logic                      im_zero;
  } side_t;

  typedef struct packed {
    logic [PROD_W-1:0]   r;
    logic [QUO_BITS-1:0] q;
    logic [LO_W-1:0]     lo;
    logic                ov;
  } dlane_t;

  typedef struct packed {
    logic [ROOT_BITS+1:0] rem;
    logic [ROOT_BITS-1:0] root;
    logic [PROD_W-1:0]    n;
  } slane_t;

  typedef struct packed {
    logic [QUO_BITS-1:0]  q_re;
    logic [QUO_BITS-1:0]  q_im;
    logic                 ov_re;
    logic                 ov_im;
    logic [ROOT_BITS-1:0] root;
  } long_t;

  function automatic logic signed [FIELD_W-1:0] sat(logic signed [SUM_W-1:0] v);
    logic signed [FIELD_W-1:0] o;
    if (v > SAT_HI) o = FIELD_W'(SAT_HI);
    else if (v < SAT_LO) o = FIELD_W'(SAT_LO);
    else o = FIELD_W'(v);
    return o;
  endfunction

  function automatic logic [4:0] msb_idx(logic [FIELD_W-1:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int k = 0; k < FIELD_W; k++) begin
      if (v[k]) idx = 5'(k);
    end
    return idx;
  endfunction

  // one restoring division step: bring in the next numerator bit
  function automatic dlane_t div_step(dlane_t d, logic [PROD_W-1:0] den);
    logic [PROD_W:0] r2;
    logic ge;
    dlane_t o;
    r2   = {d.r, d.lo[LO_W-1]};
    ge   = r2 >= {1'b0, den};
    o.r  = ge ? PROD_W'(r2 - {1'b0, den}) : PROD_W'(r2);
    o.q  = {d.q[QUO_BITS-2:0], ge};
    o.lo = d.lo << 1;
    o.ov = d.ov;
    return o;
  endfunction

  // one digit-by-digit square root step: two radicand bits in, one root bit out
  function automatic slane_t sqrt_step(slane_t s);
    logic [ROOT_BITS+3:0] r_sh;
    logic [ROOT_BITS+3:0] trial;
    logic ge;
    slane_t o;
    r_sh   = {s.rem, s.n[PROD_W-1 -: 2]};
    trial  = {2'b00, s.root, 2'b01};
    ge     = r_sh >= trial;
    o.rem  = ge ? (ROOT_BITS+2)'(r_sh - trial) : (ROOT_BITS+2)'(r_sh);
    o.root = {s.root[ROOT_BITS-2:0], ge};
    o.n    = s.n << 2;
    return o;
  endfunction

  // control and configuration
  logic                 acc;
  logic [TOL_W-1:0]     tolerance;
  logic [2*TOL_W-1:0]   tol_sq;
  logic                 vld [1:LAST];
  side_t                side_q [1:LAST];
  side_t                side1_d, side3_d;

  // operand stages
  logic signed [PROD_W-1:0]  p_rr1, p_ii1, p_ir1, p_ri1;
  logic [PROD_W-1:0]         sq_re1, sq_im1;
  logic [FIELD_W-1:0]        ux1, uy1, m1;
  logic signed [SUM_W-1:0]   ms_re2, ms_im2, ds_re2, ds_im2;
  logic [PROD_W-1:0]         den2, den3;
  logic [FIELD_W-1:0]        ux2, uy2;
  logic [5:0]                sh2;
  logic [PROD_W-1:0]         mag_re3, mag_im3;
  logic signed [ANG_W-1:0]   x3, y3;
  logic signed [FIELD_W-1:0] s_re, s_im;

  // long units
  dlane_t                d0_re, d0_im;
  dlane_t                dv_re [1:QUO_BITS];
  dlane_t                dv_im [1:QUO_BITS];
  logic [PROD_W-1:0]     dv_den [1:QUO_BITS];
  slane_t                s0;
  slane_t                sr [1:ROOT_BITS];
  long_t                 lg [1:DLY];
  logic signed [ANG_W-1:0] z_cord;

  // final stages
  logic [QUO_BITS-1:0]   qs_re_f1, qs_im_f1;
  logic [ROOT_BITS-1:0]  root_f1;
  logic [ANG_W-1:0]      theta_f1;
  logic signed [ANG_W-1:0] t_ang;
  logic [ANG_W-1:0]      ang;
  logic signed [FIELD_W-1:0] res_re_next, res_im_next;
  logic                  flag_next, fault_next;

  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      tolerance <= TOL_W'(1);
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    tol_sq <= {{TOL_W{1'b0}}, tolerance} * {{TOL_W{1'b0}}, tolerance};
  end

  // ---- stage 1: products, squares, simple operations
  always_comb begin
    logic signed [FIELD_W:0] dr, di;
    logic [FIELD_W:0]        adr, adi, aai;
    side1_d         = '0;
    side1_d.func    = func;
    side1_d.re_neg  = a_re[FIELD_W-1];
    side1_d.re_zero = (a_re == '0);
    side1_d.im_neg  = a_im[FIELD_W-1];
    side1_d.im_zero = (a_im == '0);
    dr  = (FIELD_W+1)'(a_re) - (FIELD_W+1)'(b_re);
    di  = (FIELD_W+1)'(a_im) - (FIELD_W+1)'(b_im);
    adr = dr[FIELD_W] ? -dr : dr;
    adi = di[FIELD_W] ? -di : di;
    aai = a_im[FIELD_W-1] ? -(FIELD_W+1)'(a_im) : (FIELD_W+1)'(a_im);
    case (func)
      FN_ADD: begin
        side1_d.res_re = sat(SUM_W'(a_re) + SUM_W'(b_re));
        side1_d.res_im = sat(SUM_W'(a_im) + SUM_W'(b_im));
      end
      FN_SUB: begin
        side1_d.res_re = sat(SUM_W'(a_re) - SUM_W'(b_re));
        side1_d.res_im = sat(SUM_W'(a_im) - SUM_W'(b_im));
      end
      FN_NEG: begin
        side1_d.res_re = sat(-SUM_W'(a_re));
        side1_d.res_im = sat(-SUM_W'(a_im));
      end
      FN_CONJ: begin
        side1_d.res_re = a_re;
        side1_d.res_im = sat(-SUM_W'(a_im));
      end
      FN_EQUAL: begin
        side1_d.flag = (adr < (FIELD_W+1)'(tolerance)) && (adi < (FIELD_W+1)'(tolerance));
      end
      FN_IS_REAL: begin
        side1_d.flag = aai < (FIELD_W+1)'(tolerance);
      end
      default: begin
        side1_d.flag = 1'b0;
      end
    endcase
  end

  // squares serve |b|^2 for divide and |a|^2 for magnitude and argument
  assign s_re = (func == FN_DIV) ? b_re : a_re;
  assign s_im = (func == FN_DIV) ? b_im : a_im;

  always_ff @(posedge clk) begin
    p_rr1  <= a_re * b_re;
    p_ii1  <= a_im * b_im;
    p_ir1  <= a_im * b_re;
    p_ri1  <= a_re * b_im;
    sq_re1 <= PROD_W'(s_re * s_re);
    sq_im1 <= PROD_W'(s_im * s_im);
    ux1    <= a_re[FIELD_W-1] ? FIELD_W'(-a_re) : FIELD_W'(a_re);
    uy1    <= a_im[FIELD_W-1] ? FIELD_W'(-a_im) : FIELD_W'(a_im);
  end

  assign m1 = (ux1 > uy1) ? ux1 : uy1;

  // ---- stage 2: sums, magnitude squared, normalize amount
  always_ff @(posedge clk) begin
    ms_re2 <= SUM_W'(p_rr1) - SUM_W'(p_ii1);
    ms_im2 <= SUM_W'(p_ir1) + SUM_W'(p_ri1);
    ds_re2 <= SUM_W'(p_rr1) + SUM_W'(p_ii1);
    ds_im2 <= SUM_W'(p_ir1) - SUM_W'(p_ri1);
    den2   <= sq_re1 + sq_im1;
    ux2    <= ux1;
    uy2    <= uy1;
    sh2    <= 6'(NORM_TOP) - {1'b0, msb_idx(m1)};
  end

  // ---- stage 3: saturate products, near-zero test, dividend magnitudes
  always_comb begin
    side3_d = side_q[2];
    if (side_q[2].func == FN_MUL) begin
      side3_d.res_re = sat(ms_re2 >>> FRAC_BITS);
      side3_d.res_im = sat(ms_im2 >>> FRAC_BITS);
    end
    side3_d.nz      = (side_q[2].func inside {FN_DIV, FN_ARG}) &&
                      ((den2 == '0) || (den2 < PROD_W'(tol_sq)));
    side3_d.dneg_re = ds_re2[SUM_W-1];
    side3_d.dneg_im = ds_im2[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    mag_re3 <= ds_re2[SUM_W-1] ? PROD_W'(-ds_re2) : PROD_W'(ds_re2);
    mag_im3 <= ds_im2[SUM_W-1] ? PROD_W'(-ds_im2) : PROD_W'(ds_im2);
    den3    <= den2;
    x3      <= ANG_W'(PROD_W'(ux2) << sh2);
    y3      <= ANG_W'(PROD_W'(uy2) << sh2);
  end

  // ---- divider: one quotient bit per stage, real and imaginary lanes
  always_comb begin
    d0_re.r  = PROD_W'(mag_re3[PROD_W-1:LO_W]);
    d0_re.q  = '0;
    d0_re.lo = mag_re3[LO_W-1:0];
    d0_re.ov = {{LO_W{1'b0}}, mag_re3} >= {den3, {LO_W{1'b0}}};
    d0_im.r  = PROD_W'(mag_im3[PROD_W-1:LO_W]);
    d0_im.q  = '0;
    d0_im.lo = mag_im3[LO_W-1:0];
    d0_im.ov = {{LO_W{1'b0}}, mag_im3} >= {den3, {LO_W{1'b0}}};
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    dlane_t            cur_re, cur_im;
    logic [PROD_W-1:0] cur_den;
    if (j == 0) begin : g_head
      assign cur_re  = d0_re;
      assign cur_im  = d0_im;
      assign cur_den = den3;
    end else begin : g_body
      assign cur_re  = dv_re[j];
      assign cur_im  = dv_im[j];
      assign cur_den = dv_den[j];
    end
    always_ff @(posedge clk) begin
      dv_re[j+1]  <= div_step(cur_re, cur_den);
      dv_im[j+1]  <= div_step(cur_im, cur_den);
      dv_den[j+1] <= cur_den;
    end
  end

  // ---- square root: one root bit per stage
  always_comb begin
    s0.rem  = '0;
    s0.root = '0;
    s0.n    = den3;
  end

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
    slane_t cur;
    if (j == 0) begin : g_head
      assign cur = s0;
    end else begin : g_body
      assign cur = sr[j];
    end
    always_ff @(posedge clk) begin
      sr[j+1] <= sqrt_step(cur);
    end
  end

  // hold divider and root results until the CORDIC catches up
  always_ff @(posedge clk) begin
    lg[1].q_re  <= dv_re[QUO_BITS].q;
    lg[1].q_im  <= dv_im[QUO_BITS].q;
    lg[1].ov_re <= dv_re[QUO_BITS].ov;
    lg[1].ov_im <= dv_im[QUO_BITS].ov;
    lg[1].root  <= sr[ROOT_BITS].root;
    for (int k = 2; k <= DLY; k++) lg[k] <= lg[k-1];
  end

  // ---- argument: first-quadrant angle
  cau_cordic u_cordic (
    .clk   (clk),
    .x_in  (x3),
    .y_in  (y3),
    .z_out (z_cord)
  );

  // ---- side pipeline and valid bits
  always_ff @(posedge clk) begin
    side_q[1] <= side1_d;
    side_q[2] <= side_q[1];
    side_q[3] <= side3_d;
    for (int k = 4; k <= LAST; k++) side_q[k] <= side_q[k-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAST; k++) vld[k] <= 1'b0;
    end else begin
      vld[1] <= acc;
      for (int k = 2; k <= LAST; k++) vld[k] <= vld[k-1];
    end
  end

  // ---- final stage 1: saturate quotient and root, clamp angle
  assign t_ang = z_cord >>> 2;

  always_ff @(posedge clk) begin
    if (lg[DLY].ov_re || lg[DLY].q_re > (side_q[LAST-1].dneg_re ? NEG_LIM : POS_LIM))
      qs_re_f1 <= side_q[LAST-1].dneg_re ? NEG_LIM : POS_LIM;
    else
      qs_re_f1 <= lg[DLY].q_re;
    if (lg[DLY].ov_im || lg[DLY].q_im > (side_q[LAST-1].dneg_im ? NEG_LIM : POS_LIM))
      qs_im_f1 <= side_q[LAST-1].dneg_im ? NEG_LIM : POS_LIM;
    else
      qs_im_f1 <= lg[DLY].q_im;
    root_f1 <= (lg[DLY].root > POS_LIM) ? POS_LIM : lg[DLY].root;
    if (t_ang[ANG_W-1])
      theta_f1 <= '0;
    else if (ANG_W'(t_ang) > HALF_PI_Q60)
      theta_f1 <= HALF_PI_Q60;
    else
      theta_f1 <= ANG_W'(t_ang);
  end

  // ---- final stage 2: quadrant, sign, operation select
  always_comb begin
    side_t s;
    s = side_q[LAST];
    if (!s.re_zero && !s.re_neg && s.im_zero) ang = '0;
    else if (s.re_zero && !s.im_zero && !s.im_neg) ang = HALF_PI_Q60;
    else if (s.re_neg && s.im_zero) ang = PI_Q60;
    else if (s.re_zero && s.im_neg) ang = THREE_HALF_PI_Q60;
    else if (s.re_zero && s.im_zero) ang = '0;
    else if (!s.re_neg && !s.im_neg) ang = theta_f1;
    else if (s.re_neg && !s.im_neg) ang = PI_Q60 - theta_f1;
    else if (s.re_neg) ang = PI_Q60 + theta_f1;
    else ang = TWO_PI_Q60 - theta_f1;

    res_re_next = s.res_re;
    res_im_next = s.res_im;
    flag_next   = s.flag;
    fault_next  = 1'b0;
    case (s.func)
      FN_DIV: begin
        fault_next  = s.nz;
        res_re_next = s.nz ? '0 : (s.dneg_re ? -qs_re_f1 : qs_re_f1);
        res_im_next = s.nz ? '0 : (s.dneg_im ? -qs_im_f1 : qs_im_f1);
      end
      FN_ABS: begin
        res_re_next = root_f1;
        res_im_next = '0;
      end
      FN_ARG: begin
        fault_next  = s.nz;
        res_re_next = s.nz ? '0 : FIELD_W'(ang >> ANG_SHIFT);
        res_im_next = '0;
      end
      default: begin
        fault_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    res_re <= res_re_next;
    res_im <= res_im_next;
    flag   <= flag_next;
    fault  <= fault_next;
  end

endmodule

`default_nettype wire

[sim/cau_checker.sv]
// Result checker for the complex ALU: predicts each accepted word and
// compares it with the results in arrival order. Depends on cau_pkg.
`timescale 1ns / 100ps

module cau_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [cau_pkg::FUNC_W-1:0]          func,
  input  logic signed [cau_pkg::FIELD_W-1:0]  a_re,
  input  logic signed [cau_pkg::FIELD_W-1:0]  a_im,
  input  logic signed [cau_pkg::FIELD_W-1:0]  b_re,
  input  logic signed [cau_pkg::FIELD_W-1:0]  b_im,
  input  logic                                done,
  input  logic signed [cau_pkg::FIELD_W-1:0]  res_re,
  input  logic signed [cau_pkg::FIELD_W-1:0]  res_im,
  input  logic                                flag,
  input  logic                                fault,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [cau_pkg::TOL_W-1:0]           cfg_data,
  output int                                  pending,
  output int                                  errors
);
  import cau_pkg::*;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               flag;
    logic               fault;
  } cau_result_t;

  typedef logic signed [127:0] wide_t;

  cau_result_t      result_q[$];
  logic [TOL_W-1:0] tol_reg;
  logic [63:0]      atan_tab[0:CORDIC_STEPS-1];

  initial begin
    logic [63:0] acc;
    int e;
    errors  = 0;
    pending = 0;
    tol_reg = 1;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      acc = '0;
      if (i == 0) begin
        acc = PI_Q60;
      end else begin
        for (int k = 0; k <= 30; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            if (k % 2 == 1) acc = acc - (64'd1 << (62 - e)) / (2 * k + 1);
            else acc = acc + (64'd1 << (62 - e)) / (2 * k + 1);
          end
        end
      end
      atan_tab[i] = acc;
    end
  end

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // num * 2^16 / den, truncated toward zero
  function automatic logic signed [31:0] quotient_part(wide_t num, wide_t den);
    logic [127:0] mag, q;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << FRAC_BITS) / den;
    return clamp32(neg ? -$signed(q) : $signed(q));
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] r, t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // angle in [0, 2pi) as Q60
  function automatic logic [63:0] angle_of(longint re, longint im);
    logic [63:0] ux, uy, mx, theta;
    longint x, y, z, dx, dy, t;
    if (re > 0 && im == 0) return '0;
    if (re == 0 && im > 0) return HALF_PI_Q60;
    if (re < 0 && im == 0) return PI_Q60;
    if (re == 0 && im < 0) return THREE_HALF_PI_Q60;
    if (re == 0 && im == 0) return '0;
    ux = re < 0 ? -re : re;
    uy = im < 0 ? -im : im;
    mx = ux > uy ? ux : uy;
    while (mx < (64'd1 << NORM_TOP)) begin
      ux = ux << 1;
      uy = uy << 1;
      mx = mx << 1;
    end
    x = ux;
    y = uy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_tab[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_tab[i]);
      end
    end
    t = z >>> 2;
    if (t < 0) t = 0;
    theta = t;
    if (theta > HALF_PI_Q60) theta = HALF_PI_Q60;
    if (re > 0 && im > 0) return theta;
    if (re < 0 && im > 0) return PI_Q60 - theta;
    if (re < 0) return PI_Q60 + theta;
    return TWO_PI_Q60 - theta;
  endfunction

  function automatic cau_result_t predict_result();
    cau_result_t r;
    wide_t ar, ai, br, bi, tl, den, dr, di;
    logic [63:0] ang;
    ar = a_re; ai = a_im; br = b_re; bi = b_im;
    tl = {112'b0, tol_reg};
    r = '0;
    case (func_t'(func))
      FN_ADD: begin r.re = clamp32(ar + br); r.im = clamp32(ai + bi); end
      FN_SUB: begin r.re = clamp32(ar - br); r.im = clamp32(ai - bi); end
      FN_MUL: begin
        r.re = clamp32((ar * br - ai * bi) >>> FRAC_BITS);
        r.im = clamp32((ai * br + ar * bi) >>> FRAC_BITS);
      end
      FN_DIV: begin
        den = br * br + bi * bi;
        if (den == 0 || den < tl * tl) begin
          r.fault = 1'b1;
        end else begin
          r.re = quotient_part(ar * br + ai * bi, den);
          r.im = quotient_part(ai * br - ar * bi, den);
        end
      end
      FN_NEG: begin r.re = clamp32(-ar); r.im = clamp32(-ai); end
      FN_CONJ: begin r.re = clamp32(ar); r.im = clamp32(-ai); end
      FN_ABS: r.re = clamp32({64'b0, floor_root(64'(ar * ar + ai * ai))});
      FN_ARG: begin
        den = ar * ar + ai * ai;
        if (den == 0 || den < tl * tl) begin
          r.fault = 1'b1;
        end else begin
          ang = angle_of(longint'(ar), longint'(ai));
          r.re = clamp32({64'b0, ang >> ANG_SHIFT});
        end
      end
      FN_EQUAL: begin
        dr = ar - br; di = ai - bi;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        r.flag = dr < tl && di < tl;
      end
      FN_IS_REAL: begin
        di = ai < 0 ? -ai : ai;
        r.flag = di < tl;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cau_result_t want;
    if (rst) begin
      result_q.delete();
      tol_reg = 1;
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (res_re !== want.re) begin
            $error("res_re: expected %0d, got %0d", want.re, res_re); errors++;
          end
          if (res_im !== want.im) begin
            $error("res_im: expected %0d, got %0d", want.im, res_im); errors++;
          end
          if (flag !== want.flag) begin
            $error("flag: expected %0b, got %0b", want.flag, flag); errors++;
          end
          if (fault !== want.fault) begin
            $error("fault: expected %0b, got %0b", want.fault, fault); errors++;
          end
        end
      end
      if (start && !busy) result_q.push_back(predict_result());
      // tolerance changes only after any word taken at this edge
      if (cfg_valid && cfg_ready) tol_reg = cfg_data;
    end
    pending = result_q.size();
  end

endmodule

[sim/tb_complex_arithmetic_unit.sv]
// Testbench top for the complex ALU: clock, reset, stimulus and verdict.
// Depends on cau_pkg, complex_arithmetic_unit and cau_checker.
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int LATENCY = 67;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [FUNC_W-1:0]  func = '0;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic               done;
  logic signed [31:0] res_re, res_im;
  logic               flag, fault;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TOL_W-1:0]   cfg_data = '0;
  int                 pending, errors;
  int                 cur_tol = 1;
  bit                 idling = 1'b1;

  always #4 clk = ~clk;

  complex_arithmetic_unit dut (.*);

  cau_checker checker_i (.*);

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_word(logic [3:0] f, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    start = 1'b1;
    func = f; a_re = ar; a_im = ai; b_re = br; b_im = bi;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_tol(int v);
    drain();
    cfg_valid = 1'b1;
    cfg_data = TOL_W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_tol = v;
  endtask

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4: return int'($urandom_range(0, 2097152)) - 1048576;
      5: case ($urandom_range(0, 5))
        0: return 32'h80000000;
        1: return 32'h7fffffff;
        2: return 32'h0;
        3: return 32'h1;
        4: return 32'hffffffff;
        default: return 32'h00010000;
      endcase
      6: return int'($urandom_range(0, 2 * cur_tol + 2)) - (cur_tol + 1);
      default: return int'($urandom_range(0, 33554432)) - 16777216;
    endcase
  endfunction

  task automatic random_word();
    logic [3:0] f;
    logic [31:0] ar, ai, br, bi;
    f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                     : 4'($urandom_range(0, 9));
    ar = pick_field(); ai = pick_field(); br = pick_field(); bi = pick_field();
    // keep b close to a so equality can go either way
    if (f == FN_EQUAL && $urandom_range(0, 1)) begin
      br = ar + int'($urandom_range(0, 2 * cur_tol + 2)) - (cur_tol + 1);
      bi = ai + int'($urandom_range(0, 2 * cur_tol + 2)) - (cur_tol + 1);
    end
    send_word(f, ar, ai, br, bi);
  endtask

  initial begin
    int tol_plan[6];
    tol_plan = '{0, 65535, 16, 300, 1, 0};
    repeat (3) @(negedge clk);
    rst = 1'b0;

    send_word(FN_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_word(FN_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_word(FN_MUL, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_word(FN_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_word(FN_MUL, 32'hffffffff, 32'h00000001, 32'h00000003, 32'hffffffff);
    send_word(FN_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0);
    send_word(FN_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
    send_word(FN_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_word(FN_DIV, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00010000);
    send_word(FN_NEG, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
    send_word(FN_CONJ, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
    send_word(FN_ABS, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_word(FN_ABS, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0);
    send_word(FN_ARG, 32'h00010000, 32'h0, 32'h0, 32'h0);
    send_word(FN_ARG, 32'h0, 32'h00010000, 32'h0, 32'h0);
    send_word(FN_ARG, 32'hffff0000, 32'h0, 32'h0, 32'h0);
    send_word(FN_ARG, 32'h0, 32'h80000000, 32'h0, 32'h0);
    send_word(FN_ARG, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(FN_ARG, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
    send_word(FN_ARG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_word(FN_ARG, 32'h00000003, 32'hfffffffe, 32'h0, 32'h0);
    send_word(FN_EQUAL, 32'h00010000, 32'h5, 32'h00010000, 32'h5);
    send_word(FN_IS_REAL, 32'h7fffffff, 32'h0, 32'h0, 32'h0);
    send_word(4'hf, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    repeat (150) random_word();

    foreach (tol_plan[p]) begin
      write_tol(tol_plan[p]);
      if (p == 5) idling = 1'b0;
      repeat (150) random_word();
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[complex_arithmetic_unit.f]
design/cau_pkg.sv
design/cau_cordic.sv
design/complex_arithmetic_unit.sv
sim/cau_checker.sv
sim/tb_complex_arithmetic_unit.sv
